FILE: design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int QUEUE_CAPACITY = 16;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_W-1:0]   person_id;
        logic [PRIO_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     found_id;
        logic [PRIO_W-1:0]   found_priority;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_RM_RD,
        S_RM_WR,
        S_SR_RD,
        S_SR_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/sorted_priority_queue_core.sv
// Invalid code, insert when full, remove or search when empty: the result goes straight to done.
// Insert walks from the last entry back, moving each lower-priority entry down one slot,
// then writes the new entry; remove shifts every entry up one slot; search scans from slot 0
// to the first ID match or the last entry. Each slot visited is read through the registered RAM port.
// One request in flight; the next transfer is taken once the result sits in the
// output register. Reset (synchronous, active low) empties the queue; slot RAM not cleared.
`default_nettype none

module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::QUEUE_CAPACITY
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire spq_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output spq_pkg::t_out_item     o_out_data
);

    import spq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state    r_state, n_state;
    t_in_item  r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_j, n_j;
    t_out_item r_pend, n_pend;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_slot         w_wdata;
    t_slot         w_rdata;

    logic          w_accept;
    logic          w_out_free;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_count_m1;
    logic          w_last;
    logic          w_lower;
    logic          w_id_hit;

    spq_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(CAPACITY)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_j),
        .o_rdata(w_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_count_m1 = r_count - CW'(1);
    assign w_last     = (CW'(r_j) == w_count_m1);
    assign w_lower    = (w_rdata.prio < r_req.priority_req);
    assign w_id_hit   = (w_rdata.id == r_req.person_id);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.req_type)
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_state = S_DONE;
                            end else if (w_empty) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        REQ_REMOVE: n_state = w_empty ? S_DONE : S_RM_RD;
                        REQ_SEARCH: n_state = w_empty ? S_DONE : S_SR_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD:  n_state = S_INS_CMP;
            S_INS_CMP: n_state = (w_lower && (r_j != '0)) ? S_INS_RD : S_INS_PUT;
            S_INS_PUT: n_state = S_DONE;
            S_RM_RD:   n_state = S_RM_WR;
            S_RM_WR:   n_state = w_last ? S_DONE : S_RM_RD;
            S_SR_RD:   n_state = S_SR_CMP;
            S_SR_CMP:  n_state = (w_id_hit || w_last) ? S_DONE : S_SR_RD;
            S_DONE:    n_state = w_out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_count     = r_count;
        n_j         = r_j;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_j;
        w_wdata     = w_rdata;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req                 = i_in_data;
                    n_pend.status         = STATUS_OK;
                    n_pend.found_id       = '0;
                    n_pend.found_priority = '0;
                    n_pend.entry_count    = COUNT_W'(r_count);
                    n_j                   = '0;
                    case (i_in_data.req_type)
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_pend.status = STATUS_FULL;
                            end else if (!w_empty) begin
                                n_j = w_count_m1[IW-1:0];
                            end
                        end
                        REQ_REMOVE, REQ_SEARCH: begin
                            if (w_empty) begin
                                n_pend.status = STATUS_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                if (w_lower) begin
                    w_we    = 1'b1;
                    w_waddr = r_j + 1'b1;
                    if (r_j != '0) begin
                        n_j = r_j - 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_INS_PUT: begin
                w_we               = 1'b1;
                w_waddr            = r_j;
                w_wdata.id         = r_req.person_id;
                w_wdata.prio       = r_req.priority_req;
                n_count            = r_count + 1'b1;
                n_pend.entry_count = COUNT_W'(r_count + 1'b1);
            end
            S_RM_WR: begin
                if (r_j == '0) begin
                    n_pend.found_id       = w_rdata.id;
                    n_pend.found_priority = w_rdata.prio;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_j - 1'b1;
                end
                if (w_last) begin
                    n_count            = w_count_m1;
                    n_pend.entry_count = COUNT_W'(w_count_m1);
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_SR_CMP: begin
                if (w_id_hit) begin
                    n_pend.found_id       = w_rdata.id;
                    n_pend.found_priority = w_rdata.prio;
                end else if (w_last) begin
                    n_pend.status = STATUS_NOT_FOUND;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_j    <= n_j;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("ready again right after a transfer");

    a_count_changes_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_count)
            |-> ($past(r_state) == S_INS_PUT) || ($past(r_state) == S_RM_WR))
        else $error("entry count changed outside insert or remove");

endmodule

`default_nettype wire

FILE: design/spq_ram.sv
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: tb/sorted_priority_queue_core_tb.sv
`default_nettype none

module sorted_priority_queue_core_tb;

    import spq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    logic      out_stall;
    t_out_item o_out_data;

    logic      no_idle;
    int        mismatches;
    int        stuck_cycles;

    // shadow copy of the queue, slot 0 is the highest priority
    logic [ID_W-1:0]   model_ids   [QUEUE_CAPACITY];
    logic [PRIO_W-1:0] model_prios [QUEUE_CAPACITY];
    int                model_count;

    t_out_item awaited_results [$];

    sorted_priority_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_request(input t_in_item req);
        t_out_item res;
        int        pos;
        int        i;
        res = '0;
        res.status = STATUS_OK;
        case (req.req_type)
            REQ_INSERT: begin
                if (model_count >= QUEUE_CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_count && model_prios[pos] >= req.priority_req)
                        pos++;
                    for (i = model_count; i > pos; i--) begin
                        model_ids[i]   = model_ids[i-1];
                        model_prios[i] = model_prios[i-1];
                    end
                    model_ids[pos]   = req.person_id;
                    model_prios[pos] = req.priority_req;
                    model_count++;
                end
            end
            REQ_REMOVE: begin
                if (model_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.found_id       = model_ids[0];
                    res.found_priority = model_prios[0];
                    for (i = 1; i < model_count; i++) begin
                        model_ids[i-1]   = model_ids[i];
                        model_prios[i-1] = model_prios[i];
                    end
                    model_count--;
                end
            end
            REQ_SEARCH: begin
                if (model_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.status = STATUS_NOT_FOUND;
                    for (i = 0; i < model_count; i++) begin
                        if (res.status == STATUS_NOT_FOUND && model_ids[i] == req.person_id) begin
                            res.status         = STATUS_OK;
                            res.found_id       = model_ids[i];
                            res.found_priority = model_prios[i];
                        end
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = model_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic t_in_item make_item(input logic [REQ_W-1:0] req,
                                           input logic [ID_W-1:0] id,
                                           input logic [PRIO_W-1:0] prio);
        t_in_item item;
        item.req_type     = req;
        item.person_id    = id;
        item.priority_req = prio;
        return item;
    endfunction

    function automatic t_in_item random_request(input int insert_pct);
        t_in_item item;
        int       r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:          item.person_id = '0;
            1:          item.person_id = '1;
            2, 3, 4, 5: item.person_id = ID_W'($urandom_range(0, 15));
            default:    item.person_id = ID_W'($urandom);
        endcase
        if ($urandom_range(0, 9) < 4)
            item.priority_req = PRIO_W'($urandom_range(0, 3) * 85);
        else
            item.priority_req = PRIO_W'($urandom_range(0, 255));
        if (r < 4)
            item.req_type = REQ_UNUSED;
        else if (r < 4 + insert_pct * 96 / 100)
            item.req_type = REQ_INSERT;
        else if (r[0])
            item.req_type = REQ_REMOVE;
        else
            item.req_type = REQ_SEARCH;
        if (item.req_type == REQ_SEARCH && model_count > 0 && $urandom_range(0, 9) < 6)
            item.person_id = model_ids[$urandom_range(0, model_count - 1)];
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input t_in_item item);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        in_valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed_corners();
        logic [ID_W+PRIO_W-1:0] fill_list [QUEUE_CAPACITY] = '{
            24'h0000_00, 24'hFFFF_FF, 24'h1234_80, 24'h0001_80,
            24'h1234_40, 24'hAAAA_FF, 24'h5555_00, 24'h0002_7F,
            24'h0003_81, 24'h8000_01, 24'h7FFF_FE, 24'h0004_80,
            24'h00FF_10, 24'hFF00_EF, 24'h0F0F_33, 24'hF0F0_CC
        };
        send_request(make_item(REQ_REMOVE, 16'h0000, 8'h00));
        send_request(make_item(REQ_SEARCH, 16'hFFFF, 8'hFF));
        send_request(make_item(REQ_UNUSED, 16'hFFFF, 8'hFF));
        foreach (fill_list[k])
            send_request(make_item(REQ_INSERT, fill_list[k][ID_W+PRIO_W-1:PRIO_W],
                                   fill_list[k][PRIO_W-1:0]));
        send_request(make_item(REQ_INSERT, 16'h4242, 8'hFF));
        send_request(make_item(REQ_UNUSED, 16'h0000, 8'h00));
        send_request(make_item(REQ_SEARCH, 16'h1234, 8'h00));
        send_request(make_item(REQ_SEARCH, 16'h5555, 8'h00));
        send_request(make_item(REQ_SEARCH, 16'hBEEF, 8'h00));
    endtask

    task automatic test_random_mix();
        repeat (380) send_request(random_request(45));
    endtask

    task automatic test_fill_and_drain();
        repeat (6) begin
            repeat (20) send_request(random_request(85));
            repeat (20) send_request(random_request(10));
        end
    endtask

    task automatic test_pause_until_drained();
        repeat (30) send_request(random_request(60));
        wait_until_drained();
        repeat (30) send_request(random_request(40));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (150) send_request(random_request(50));
    endtask

    task automatic flag_field(input string field, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall)
                awaited_results.push_back(predict_request(in_data));
            if (o_out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    flag_field("status", ID_W'(exp_res.status),
                               ID_W'(o_out_data.status));
                    flag_field("found_id", exp_res.found_id, o_out_data.found_id);
                    flag_field("found_priority", ID_W'(exp_res.found_priority),
                               ID_W'(o_out_data.found_priority));
                    flag_field("entry_count", ID_W'(exp_res.entry_count),
                               ID_W'(o_out_data.entry_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            if (no_idle) begin
                out_stall = 1'b0;
                @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
                out_stall = !no_idle;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    initial begin
        in_valid     = 1'b0;
        in_data      = '0;
        i_rst_n      = 1'b0;
        no_idle      = 1'b0;
        mismatches   = 0;
        stuck_cycles = 0;
        model_count  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_corners();
        test_random_mix();
        test_fill_and_drain();
        test_pause_until_drained();
        test_back_to_back();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
